@@ hw/rtl/rswa_pkg.sv @@
// shared widths, flag type and defaults for the running series window statistics block
package rswa_pkg;

  // parameter defaults
  localparam int unsigned MaxWindowDef = 31;
  localparam int unsigned HistDepthDef = 64;

  // configuration register
  localparam int unsigned CfgW        = 5;
  localparam int unsigned WindowReset = 7;

  // series and result widths
  localparam int unsigned PosW        = 31;
  localparam int unsigned TestW       = 32;
  localparam int unsigned PosDeltaW   = 32;
  localparam int unsigned TestDeltaW  = 33;
  localparam int unsigned PosAvgW     = 40;
  localparam int unsigned TestAvgW    = 41;
  localparam int unsigned PosSlopeW   = 41;
  localparam int unsigned TestSlopeW  = 43;

  // fixed point and divider widths
  localparam int unsigned FracW = 8;
  localparam int unsigned NumW  = 34;
  localparam int unsigned DivW  = NumW + FracW;

  // item queue between front and back
  localparam int unsigned QueueDepth = 2;

  // per-item classification from the front
  typedef struct packed {
    logic first;
    logic avg_on;
    logic ds_on;
    logic as_on;
  } rswa_flags_t;

endpackage

@@ hw/rtl/rswa_div.sv @@
// iterative restoring divider, one quotient bit per cycle, rounds to nearest
module rswa_div import rswa_pkg::*; #(
  parameter int unsigned DvdW = DivW,
  parameter int unsigned DenW = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DvdW-1:0] dividend_i,
  input  logic [DenW-1:0] divisor_i,
  output logic            done_o,
  output logic [DvdW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(DvdW);

  typedef enum logic [1:0] {DivIdle, DivRun, DivRound} div_state_e;

  div_state_e      state_q;
  logic [CntW-1:0] cnt_q;
  logic            done_q;
  logic [DvdW-1:0] quo_q;
  logic [DenW-1:0] rem_q;
  logic [DenW-1:0] den_q;
  logic [DenW:0]   shifted;
  logic [DenW:0]   rem_d;
  logic            ge;
  logic            rnd_up;

  // one compare and subtract step
  always_comb begin
    shifted = {rem_q, quo_q[DvdW-1]};
    ge      = shifted >= {1'b0, den_q};
    rem_d   = ge ? (shifted - {1'b0, den_q}) : shifted;
    rnd_up  = {rem_q, 1'b0} >= {1'b0, den_q};
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DivIdle;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else if (start_i) begin
      state_q <= DivRun;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      case (state_q)
        DivRun: begin
          if (cnt_q == CntW'(DvdW - 1)) begin
            state_q <= DivRound;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        DivRound: begin
          state_q <= DivIdle;
          done_q  <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // dividend shifts out as quotient bits shift in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (state_q == DivRun) begin
      quo_q <= {quo_q[DvdW-2:0], ge};
      rem_q <= rem_d[DenW-1:0];
    end else if (state_q == DivRound && rnd_up) begin
      quo_q <= quo_q + DvdW'(1);
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

@@ hw/rtl/rswa_queue.sv @@
// short item queue between the front and the back
module rswa_queue import rswa_pkg::*; #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] slots_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q;
  logic [PtrW-1:0]  rd_ptr_q;
  logic [CntW-1:0]  count_q;

  assign full_o  = count_q == CntW'(Depth);
  assign empty_o = count_q == '0;
  assign data_o  = slots_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ hw/rtl/rswa_front.sv @@
// front end: window register, item intake, row counting and classification
module rswa_front import rswa_pkg::*; #(
  parameter int unsigned MaxWindow = MaxWindowDef,
  parameter int unsigned HistDepth = HistDepthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [CfgW-1:0]                cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [PosW-1:0]                positive_count_i,
  input  logic [PosW-1:0]                negative_count_i,
  input  logic                           q_full_i,
  output logic                           q_push_o,
  output logic [PosW-1:0]                p_o,
  output logic [TestW-1:0]               t_o,
  output logic [$clog2(HistDepth)-1:0]   slot_o,
  output logic [$clog2(MaxWindow+1)-1:0] d_o,
  output rswa_flags_t                    flags_o
);

  localparam int unsigned AW       = $clog2(HistDepth);
  localparam int unsigned DW       = $clog2(MaxWindow + 1);
  localparam int unsigned CW       = $clog2(2 * MaxWindow + 2);
  localparam int unsigned CountCap = 2 * MaxWindow + 1;

  logic [CfgW-1:0] window_q;
  logic [CW-1:0]   count_q;
  logic [AW-1:0]   slot_q;
  logic [DW-1:0]   d;
  logic [CW:0]     row_x;
  logic [CW:0]     d_x;
  logic            on;

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // window length, clamped to the supported maximum
  always_comb begin
    if (32'(window_q) > 32'(MaxWindow)) begin
      d = DW'(MaxWindow);
    end else begin
      d = DW'(window_q);
    end
  end

  // row classification against the window
  always_comb begin
    row_x          = (CW+1)'(count_q);
    d_x            = (CW+1)'(d);
    on             = d_x > (CW+1)'(2);
    flags_o.first  = count_q == '0;
    flags_o.avg_on = on && (row_x >= d_x);
    flags_o.ds_on  = on && (row_x >= d_x + 1'b1);
    flags_o.as_on  = on && (row_x >= (d_x << 1));
  end

  assign p_o    = positive_count_i;
  assign t_o    = TestW'(positive_count_i) + TestW'(negative_count_i);
  assign slot_o = slot_q;
  assign d_o    = d;

  // window register, saturating row count and write slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= CfgW'(WindowReset);
      count_q  <= '0;
      slot_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end
      if (q_push_o) begin
        if (count_q < CW'(CountCap)) begin
          count_q <= count_q + 1'b1;
        end
        slot_q <= (slot_q == AW'(HistDepth - 1)) ? '0 : slot_q + 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/rswa_back.sv @@
// back end: history memory, difference arithmetic, dividers and result register
module rswa_back import rswa_pkg::*; #(
  parameter int unsigned MaxWindow = MaxWindowDef,
  parameter int unsigned HistDepth = HistDepthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_empty_i,
  output logic                           q_pop_o,
  input  logic [PosW-1:0]                p_i,
  input  logic [TestW-1:0]               t_i,
  input  logic [$clog2(HistDepth)-1:0]   slot_i,
  input  logic [$clog2(MaxWindow+1)-1:0] d_i,
  input  rswa_flags_t                    flags_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [PosW-1:0]                pos_value_o,
  output logic [PosDeltaW-1:0]           pos_delta_o,
  output logic [PosDeltaW-1:0]           pos_since_first_o,
  output logic [PosAvgW-1:0]             pos_window_avg_o,
  output logic [PosSlopeW-1:0]           pos_delta_slope_o,
  output logic [PosSlopeW-1:0]           pos_avg_slope_o,
  output logic [TestW-1:0]               test_value_o,
  output logic [TestDeltaW-1:0]          test_delta_o,
  output logic [TestDeltaW-1:0]          test_since_first_o,
  output logic [TestAvgW-1:0]            test_window_avg_o,
  output logic [TestSlopeW-1:0]          test_delta_slope_o,
  output logic [TestSlopeW-1:0]          test_avg_slope_o
);

  localparam int unsigned AW      = $clog2(HistDepth);
  localparam int unsigned DW      = $clog2(MaxWindow + 1);
  localparam int unsigned XW      = ((AW > DW) ? AW : DW) + 1;
  localparam int unsigned DenW    = 2 * DW;
  localparam int unsigned NSer    = 2;
  localparam int unsigned NKind   = 3;
  localparam int unsigned NDiv    = NSer * NKind;
  localparam int unsigned KindAvg = 0;
  localparam int unsigned KindDs  = 1;
  localparam int unsigned KindAs  = 2;
  localparam int unsigned MemW    = PosW + TestW;

  typedef enum logic [3:0] {
    StIdle, StReduce, StRd1, StRdD, StRdD1, StRd2D, StLast,
    StCalc1, StCalc2, StCalc3, StDivWait, StFin
  } state_e;

  state_e state_q, state_d;

  // history memory
  logic [MemW-1:0] hist_mem [HistDepth];
  logic [MemW-1:0] rd_q;
  logic [AW-1:0]   rd_addr;

  // item working registers
  logic [TestW-1:0]        cur_q   [NSer];
  logic [TestW-1:0]        first_q [NSer];
  logic [TestW-1:0]        h1_q    [NSer];
  logic [TestW-1:0]        hd_q    [NSer];
  logic [TestW-1:0]        hd1_q   [NSer];
  logic [TestW-1:0]        h2d_q   [NSer];
  logic signed [TestW:0]   e1_q    [NSer];
  logic signed [TestW:0]   ed_q    [NSer];
  logic signed [TestW:0]   f_q     [NSer];
  logic signed [TestW:0]   g_q     [NSer];
  logic signed [TestW:0]   sf_q    [NSer];
  logic signed [NumW-1:0]  num_q   [NDiv];
  logic                    sign_q  [NDiv];
  rswa_flags_t             flags_q;
  logic [AW-1:0]           slot_q;
  logic [AW-1:0]           ad_q;
  logic [DW-1:0]           dm_q;
  logic [DW-1:0]           d_q;
  logic [DenW-1:0]         dsq_q;

  // divider hookup
  logic                    div_start;
  logic [NumW-1:0]         mag      [NDiv];
  logic [DivW-1:0]         quot     [NDiv];
  logic [NDiv-1:0]         div_done;
  logic signed [DivW:0]    res      [NDiv];
  logic                    dm_big;
  logic                    out_free;
  logic                    out_valid_q;

  // result register
  logic [PosW-1:0]       pos_value_q;
  logic [PosDeltaW-1:0]  pos_delta_q;
  logic [PosDeltaW-1:0]  pos_since_first_q;
  logic [PosAvgW-1:0]    pos_window_avg_q;
  logic [PosSlopeW-1:0]  pos_delta_slope_q;
  logic [PosSlopeW-1:0]  pos_avg_slope_q;
  logic [TestW-1:0]      test_value_q;
  logic [TestDeltaW-1:0] test_delta_q;
  logic [TestDeltaW-1:0] test_since_first_q;
  logic [TestAvgW-1:0]   test_window_avg_q;
  logic [TestSlopeW-1:0] test_delta_slope_q;
  logic [TestSlopeW-1:0] test_avg_slope_q;

  // slot minus an offset below the depth, wrapping round the memory
  function automatic logic [AW-1:0] wrap_sub(input logic [AW-1:0] a, input logic [XW-1:0] b);
    logic [XW-1:0] diff;
    diff = XW'(a) - b;
    if (XW'(a) < b) begin
      diff = diff + XW'(HistDepth);
    end
    return diff[AW-1:0];
  endfunction

  function automatic logic signed [TestW:0] sdiff(input logic [TestW-1:0] a,
                                                  input logic [TestW-1:0] b);
    return $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  assign q_pop_o   = (state_q == StIdle) && !q_empty_i;
  assign dm_big    = 32'(dm_q) >= 32'(HistDepth);
  assign div_start = state_q == StCalc3;
  assign out_free  = !out_valid_q || out_ready_i;

  // read address per look-back step
  always_comb begin
    case (state_q)
      StRdD:   rd_addr = ad_q;
      StRdD1:  rd_addr = wrap_sub(ad_q, XW'(1));
      StRd2D:  rd_addr = wrap_sub(ad_q, XW'(dm_q));
      default: rd_addr = wrap_sub(slot_q, XW'(1));
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:    if (!q_empty_i) state_d = StReduce;
      StReduce:  if (!dm_big) state_d = StRd1;
      StRd1:     state_d = StRdD;
      StRdD:     state_d = StRdD1;
      StRdD1:    state_d = StRd2D;
      StRd2D:    state_d = StLast;
      StLast:    state_d = StCalc1;
      StCalc1:   state_d = StCalc2;
      StCalc2:   state_d = StCalc3;
      StCalc3:   state_d = StDivWait;
      StDivWait: if (&div_done) state_d = StFin;
      StFin:     if (out_free) state_d = StIdle;
      default:   state_d = StIdle;
    endcase
  end

  // memory write of the new sample and registered read
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      hist_mem[slot_i] <= {p_i, t_i};
    end
    rd_q <= hist_mem[rd_addr];
  end

  // first samples
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q[0] <= '0;
      first_q[1] <= '0;
    end else if (q_pop_o && flags_i.first) begin
      first_q[0] <= TestW'(p_i);
      first_q[1] <= t_i;
    end
  end

  // datapath registers stepped by the sequencer
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (!q_empty_i) begin
          cur_q[0] <= TestW'(p_i);
          cur_q[1] <= t_i;
          slot_q   <= slot_i;
          dm_q     <= d_i;
          d_q      <= d_i;
          flags_q  <= flags_i;
        end
      end
      StReduce: begin
        if (dm_big) begin
          dm_q <= dm_q - DW'(HistDepth);
        end else begin
          ad_q <= wrap_sub(slot_q, XW'(dm_q));
        end
      end
      StRdD: begin
        h1_q[0] <= TestW'(rd_q[MemW-1:TestW]);
        h1_q[1] <= rd_q[TestW-1:0];
      end
      StRdD1: begin
        hd_q[0] <= TestW'(rd_q[MemW-1:TestW]);
        hd_q[1] <= rd_q[TestW-1:0];
      end
      StRd2D: begin
        hd1_q[0] <= TestW'(rd_q[MemW-1:TestW]);
        hd1_q[1] <= rd_q[TestW-1:0];
      end
      StLast: begin
        h2d_q[0] <= TestW'(rd_q[MemW-1:TestW]);
        h2d_q[1] <= rd_q[TestW-1:0];
      end
      StCalc1: begin
        for (int s = 0; s < NSer; s++) begin
          e1_q[s] <= flags_q.first ? '0 : sdiff(cur_q[s], h1_q[s]);
          ed_q[s] <= sdiff(hd_q[s], hd1_q[s]);
          f_q[s]  <= sdiff(cur_q[s], hd_q[s]);
          g_q[s]  <= sdiff(hd_q[s], h2d_q[s]);
          sf_q[s] <= sdiff(cur_q[s], first_q[s]);
        end
      end
      StCalc2: begin
        for (int s = 0; s < NSer; s++) begin
          num_q[NKind*s+KindAvg] <= flags_q.avg_on ? NumW'(f_q[s]) : '0;
          num_q[NKind*s+KindDs]  <= flags_q.ds_on ? NumW'(e1_q[s]) - NumW'(ed_q[s]) : '0;
          num_q[NKind*s+KindAs]  <= flags_q.as_on ? NumW'(f_q[s]) - NumW'(g_q[s]) : '0;
        end
        dsq_q <= DenW'(d_q) * DenW'(d_q);
      end
      StCalc3: begin
        for (int j = 0; j < NDiv; j++) begin
          sign_q[j] <= num_q[j] < 0;
        end
      end
      default: ;
    endcase
  end

  // magnitudes into the dividers, signs back onto the quotients
  always_comb begin
    for (int j = 0; j < NDiv; j++) begin
      mag[j] = (num_q[j] < 0) ? NumW'(-num_q[j]) : NumW'(num_q[j]);
      res[j] = sign_q[j] ? -$signed({1'b0, quot[j]}) : $signed({1'b0, quot[j]});
    end
  end

  // one divider per average and slope result, all run side by side
  for (genvar j = 0; j < NDiv; j++) begin : g_div
    rswa_div #(
      .DvdW (DivW),
      .DenW (DenW)
    ) u_div (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .start_i    (div_start),
      .dividend_i ({mag[j], FracW'(0)}),
      .divisor_i  (((j % NKind) == KindAs) ? dsq_q : DenW'(d_q)),
      .done_o     (div_done[j]),
      .quot_o     (quot[j])
    );
  end

  // sequencer state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q            <= StIdle;
      out_valid_q        <= 1'b0;
      pos_value_q        <= '0;
      pos_delta_q        <= '0;
      pos_since_first_q  <= '0;
      pos_window_avg_q   <= '0;
      pos_delta_slope_q  <= '0;
      pos_avg_slope_q    <= '0;
      test_value_q       <= '0;
      test_delta_q       <= '0;
      test_since_first_q <= '0;
      test_window_avg_q  <= '0;
      test_delta_slope_q <= '0;
      test_avg_slope_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StFin && out_free) begin
        out_valid_q        <= 1'b1;
        pos_value_q        <= cur_q[0][PosW-1:0];
        pos_delta_q        <= e1_q[0][PosDeltaW-1:0];
        pos_since_first_q  <= sf_q[0][PosDeltaW-1:0];
        pos_window_avg_q   <= flags_q.avg_on ? res[KindAvg][PosAvgW-1:0]
                                             : {e1_q[0][PosDeltaW-1:0], FracW'(0)};
        pos_delta_slope_q  <= flags_q.ds_on ? res[KindDs][PosSlopeW-1:0] : '0;
        pos_avg_slope_q    <= flags_q.as_on ? res[KindAs][PosSlopeW-1:0] : '0;
        test_value_q       <= cur_q[1];
        test_delta_q       <= e1_q[1][TestDeltaW-1:0];
        test_since_first_q <= sf_q[1][TestDeltaW-1:0];
        test_window_avg_q  <= flags_q.avg_on ? res[NKind+KindAvg][TestAvgW-1:0]
                                             : {e1_q[1][TestDeltaW-1:0], FracW'(0)};
        test_delta_slope_q <= flags_q.ds_on ? res[NKind+KindDs][TestSlopeW-1:0] : '0;
        test_avg_slope_q   <= flags_q.as_on ? res[NKind+KindAs][TestSlopeW-1:0] : '0;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign pos_value_o        = pos_value_q;
  assign pos_delta_o        = pos_delta_q;
  assign pos_since_first_o  = pos_since_first_q;
  assign pos_window_avg_o   = pos_window_avg_q;
  assign pos_delta_slope_o  = pos_delta_slope_q;
  assign pos_avg_slope_o    = pos_avg_slope_q;
  assign test_value_o       = test_value_q;
  assign test_delta_o       = test_delta_q;
  assign test_since_first_o = test_since_first_q;
  assign test_window_avg_o  = test_window_avg_q;
  assign test_delta_slope_o = test_delta_slope_q;
  assign test_avg_slope_o   = test_avg_slope_q;

endmodule

@@ hw/rtl/running_series_window_statistics_top.sv @@
// top level of the running series window statistics block
//
// Input channel (in_valid_i / in_ready_o) takes one day's cumulative positive
// and negative counts per item; output channel (out_valid_o / out_ready_i)
// gives one result item per input item, in order, with value, daily change,
// change since the first day, window average and the two slopes for the
// positive series and the tests series (averages and slopes signed Q.8).
// cfg_we_i / cfg_wdata_i write the window length at once, no handshake.
// A front stage counts rows and classifies each item, then a two-entry
// queue hands it to the back, which reads four look-back samples from the
// history memory and runs six 42-step restoring dividers side by side.
// The back starts on a new item only once the last result has entered the
// output register; the divider length sets most of the time an item takes.
// If the history depth is not above the window length, the back first folds
// the window length below the depth, one depth at a time, in its reduce state.
// Reset restores the window length to 7 and clears row count, write slot and
// first samples; the history memory needs no clearing.
// When the receiver stalls, the result waits in the output register, the
// back holds its next result, and the queue keeps taking items until full.
module running_series_window_statistics_top import rswa_pkg::*; #(
  parameter int unsigned MaxWindow = MaxWindowDef,
  parameter int unsigned HistDepth = HistDepthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgW-1:0]       cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [PosW-1:0]       positive_count_i,
  input  logic [PosW-1:0]       negative_count_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PosW-1:0]       pos_value_o,
  output logic [PosDeltaW-1:0]  pos_delta_o,
  output logic [PosDeltaW-1:0]  pos_since_first_o,
  output logic [PosAvgW-1:0]    pos_window_avg_o,
  output logic [PosSlopeW-1:0]  pos_delta_slope_o,
  output logic [PosSlopeW-1:0]  pos_avg_slope_o,
  output logic [TestW-1:0]      test_value_o,
  output logic [TestDeltaW-1:0] test_delta_o,
  output logic [TestDeltaW-1:0] test_since_first_o,
  output logic [TestAvgW-1:0]   test_window_avg_o,
  output logic [TestSlopeW-1:0] test_delta_slope_o,
  output logic [TestSlopeW-1:0] test_avg_slope_o
);

  localparam int unsigned AW = $clog2(HistDepth);
  localparam int unsigned DW = $clog2(MaxWindow + 1);
  localparam int unsigned FW = $bits(rswa_flags_t);
  localparam int unsigned QW = FW + DW + AW + TestW + PosW;

  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;
  logic [QW-1:0]     q_wdata;
  logic [QW-1:0]     q_rdata;
  logic [PosW-1:0]   f_p;
  logic [TestW-1:0]  f_t;
  logic [AW-1:0]     f_slot;
  logic [DW-1:0]     f_d;
  rswa_flags_t       f_flags;
  logic [PosW-1:0]   b_p;
  logic [TestW-1:0]  b_t;
  logic [AW-1:0]     b_slot;
  logic [DW-1:0]     b_d;
  rswa_flags_t       b_flags;

  // intake and classification
  rswa_front #(
    .MaxWindow (MaxWindow),
    .HistDepth (HistDepth)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .positive_count_i (positive_count_i),
    .negative_count_i (negative_count_i),
    .q_full_i         (q_full),
    .q_push_o         (q_push),
    .p_o              (f_p),
    .t_o              (f_t),
    .slot_o           (f_slot),
    .d_o              (f_d),
    .flags_o          (f_flags)
  );

  // item queue
  assign q_wdata = {f_flags, f_d, f_slot, f_t, f_p};
  assign {b_flags, b_d, b_slot, b_t, b_p} = q_rdata;

  rswa_queue #(
    .Width (QW),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  // history, arithmetic and results
  rswa_back #(
    .MaxWindow (MaxWindow),
    .HistDepth (HistDepth)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_empty_i          (q_empty),
    .q_pop_o            (q_pop),
    .p_i                (b_p),
    .t_i                (b_t),
    .slot_i             (b_slot),
    .d_i                (b_d),
    .flags_i            (b_flags),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .pos_value_o        (pos_value_o),
    .pos_delta_o        (pos_delta_o),
    .pos_since_first_o  (pos_since_first_o),
    .pos_window_avg_o   (pos_window_avg_o),
    .pos_delta_slope_o  (pos_delta_slope_o),
    .pos_avg_slope_o    (pos_avg_slope_o),
    .test_value_o       (test_value_o),
    .test_delta_o       (test_delta_o),
    .test_since_first_o (test_since_first_o),
    .test_window_avg_o  (test_window_avg_o),
    .test_delta_slope_o (test_delta_slope_o),
    .test_avg_slope_o   (test_avg_slope_o)
  );

`ifndef SYNTH
  // back never takes an item from an empty queue
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("item taken from empty queue");

  // back works on one item at a time
  a_pop_spaced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> !q_pop)
    else $error("back took two items in a row");

  // tests series is never below the positive series
  a_test_ge_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (test_value_o >= TestW'(pos_value_o)))
    else $error("tests value below positive value");
`endif

endmodule
